[hdl/msms_pkg.sv]
// shared types, constants and level tables for the stream count and mcs selector
package msms_pkg;

    localparam int MAX_ANTENNAS_DEF = 4;
    localparam int LANES            = 4;
    localparam int LEVEL_W          = 4;
    localparam int THR_W            = 11;
    localparam int RATE_W           = 8;
    localparam int CNT_W            = 3;

    localparam logic [LEVEL_W-1:0] TOP_LEVEL = 4'd8;
    localparam logic [LEVEL_W-1:0] PAD_LEVEL = 4'd15;
    localparam logic [CNT_W-1:0]   CNT_RESET = 3'd2;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef level_t [LANES-1:0] level_vec_t;

    typedef struct packed {
        logic [3:0] level_a;
        logic [3:0] level_b;
        logic [3:0] level_c;
        logic [3:0] level_d;
    } in_beat_t;

    typedef struct packed {
        logic [4:0] mcs_with_streams;
        logic [2:0] stream_count;
        logic [2:0] stream_mcs;
        logic [9:0] total_rate;
    } out_beat_t;

    // snr thresholds in hundredths of a db
    function automatic logic [THR_W-1:0] thr_of(input level_t lvl);
        logic [THR_W-1:0] v;
        unique case (lvl)
            4'd0:    v = 11'd0;
            4'd1:    v = 11'd50;
            4'd2:    v = 11'd250;
            4'd3:    v = 11'd300;
            4'd4:    v = 11'd450;
            4'd5:    v = 11'd530;
            4'd6:    v = 11'd912;
            4'd7:    v = 11'd1050;
            default: v = 11'd1100;
        endcase
        return v;
    endfunction

    // per-stream rate in half mbit/s
    function automatic logic [RATE_W-1:0] rate_of(input level_t lvl);
        logic [RATE_W-1:0] v;
        unique case (lvl)
            4'd0:    v = 8'd0;
            4'd1:    v = 8'd13;
            4'd2:    v = 8'd26;
            4'd3:    v = 8'd39;
            4'd4:    v = 8'd52;
            4'd5:    v = 8'd78;
            4'd6:    v = 8'd104;
            4'd7:    v = 8'd117;
            default: v = 8'd130;
        endcase
        return v;
    endfunction

endpackage

[hdl/mimo_stream_count_mcs_select.sv]
// top level: input register, decision logic, result register, antenna count register
//
//  channel | ports                     | beat
//  --------+---------------------------+-----------------------------
//  input   | s_valid s_ready s_data    | four antenna levels
//  result  | m_valid m_ready m_data    | mcs, streams, rate
//  config  | cfg_we cfg_wdata          | antenna count, no read-back
//
// beats pass input then result register, one beat per cycle while m_ready is high
// the decision sits between the input register and the result register
// aresetn clears both valid flags and loads an antenna count of two
// a stalled result holds the result register, the input register refills behind it
module mimo_stream_count_mcs_select
    import msms_pkg::*;
#(
    parameter int MAX_ANTENNAS = MAX_ANTENNAS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data
);

    logic [CNT_W-1:0] count_reg;
    logic             in_valid_reg;
    in_beat_t         in_data_reg;
    logic             m_valid_reg;
    out_beat_t        m_data_reg;
    out_beat_t        result_next;
    logic             out_load;

    assign out_load = !m_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_load;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_RESET;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    msms_select #(
        .MAX_ANTENNAS (MAX_ANTENNAS)
    ) u_select (
        .beat          (in_data_reg),
        .antenna_count (count_reg),
        .result        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            m_data_reg <= result_next;
        end
    end

endmodule

[hdl/msms_sort.sv]
// four-lane ascending compare-exchange network
module msms_sort
    import msms_pkg::*;
(
    input  level_vec_t lv_in,
    output level_vec_t lv_out
);

    level_vec_t st1;
    level_vec_t st2;

    always_comb begin
        st1 = lv_in;
        if (lv_in[0] > lv_in[1]) begin
            st1[0] = lv_in[1];
            st1[1] = lv_in[0];
        end
        if (lv_in[2] > lv_in[3]) begin
            st1[2] = lv_in[3];
            st1[3] = lv_in[2];
        end

        st2 = st1;
        if (st1[0] > st1[2]) begin
            st2[0] = st1[2];
            st2[2] = st1[0];
        end
        if (st1[1] > st1[3]) begin
            st2[1] = st1[3];
            st2[3] = st1[1];
        end

        lv_out = st2;
        if (st2[1] > st2[2]) begin
            lv_out[1] = st2[2];
            lv_out[2] = st2[1];
        end
    end

endmodule

[hdl/msms_select.sv]
// stream count and per-stream mcs decision for one beat
module msms_select
    import msms_pkg::*;
#(
    parameter int MAX_ANTENNAS = MAX_ANTENNAS_DEF
) (
    input  in_beat_t         beat,
    input  logic [CNT_W-1:0] antenna_count,
    output out_beat_t        result
);

    logic [CNT_W-1:0]          n;
    level_vec_t                raw;
    level_vec_t                padded;
    level_vec_t                sorted;
    logic                      all_zero;
    logic [THR_W+CNT_W-1:0]    base_thr;
    level_t    [LANES-1:0]     cand_lvl;
    logic      [LANES-1:0][CNT_W-1:0] cand_d;
    logic      [LANES-1:0][RATE_W+CNT_W-1:0] cand_total;
    logic [CNT_W-1:0]          best_d;
    level_t                    best_lvl;
    logic [RATE_W+CNT_W-1:0]   best_total;
    logic [2:0]                mcs;
    logic [CNT_W-1:0]          dm1;

    always_comb begin
        if (antenna_count == '0) begin
            n = CNT_W'(1);
        end else if (antenna_count > CNT_W'(MAX_ANTENNAS)) begin
            n = CNT_W'(MAX_ANTENNAS);
        end else begin
            n = antenna_count;
        end
    end

    assign raw[0] = beat.level_a;
    assign raw[1] = beat.level_b;
    assign raw[2] = beat.level_c;
    assign raw[3] = beat.level_d;

    // saturate, and push unused lanes above every real level
    always_comb begin
        all_zero = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            if (CNT_W'(i) < n) begin
                padded[i] = (raw[i] > TOP_LEVEL) ? TOP_LEVEL : raw[i];
                if (raw[i] != '0) all_zero = 1'b0;
            end else begin
                padded[i] = PAD_LEVEL;
            end
        end
    end

    msms_sort u_sort (
        .lv_in  (padded),
        .lv_out (sorted)
    );

    // for every candidate but the full stream count, raise the weakest kept level as far as the scaled threshold allows
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            cand_d[i]   = n - CNT_W'(i);
            cand_lvl[i] = sorted[i];
            base_thr    = (THR_W+CNT_W)'(n) * (THR_W+CNT_W)'(thr_of(sorted[i]));
            if (i != 0) begin
                for (int t = 1; t <= 8; t++) begin
                    if ((LEVEL_W'(t) > sorted[i]) &&
                        (base_thr >= (THR_W+CNT_W)'(cand_d[i]) *
                                     (THR_W+CNT_W)'(thr_of(LEVEL_W'(t))))) begin
                        cand_lvl[i] = LEVEL_W'(t);
                    end
                end
            end
            cand_total[i] = (RATE_W+CNT_W)'(cand_d[i]) *
                            (RATE_W+CNT_W)'(rate_of(cand_lvl[i]));
        end
    end

    always_comb begin
        best_d     = cand_d[0];
        best_lvl   = cand_lvl[0];
        best_total = cand_total[0];
        for (int i = 1; i < LANES; i++) begin
            if ((CNT_W'(i) < n) && (cand_total[i] > best_total)) begin
                best_d     = cand_d[i];
                best_lvl   = cand_lvl[i];
                best_total = cand_total[i];
            end
        end
    end

    assign mcs = 3'(best_lvl - LEVEL_W'(1));
    assign dm1 = best_d - CNT_W'(1);

    always_comb begin
        if (all_zero) begin
            result.mcs_with_streams = '0;
            result.stream_count     = 3'd1;
            result.stream_mcs       = '0;
            result.total_rate       = 10'(rate_of(LEVEL_W'(1)));
        end else begin
            result.mcs_with_streams = {dm1[1:0], mcs};
            result.stream_count     = best_d;
            result.stream_mcs       = mcs;
            result.total_rate       = best_total[9:0];
        end
    end

endmodule
